@@ rtl/entropy_autofocus_gradient_macros.svh @@
// Assertion macros for the entropy autofocus gradient block
`ifndef ENTROPY_AUTOFOCUS_GRADIENT_MACROS_SVH
`define ENTROPY_AUTOFOCUS_GRADIENT_MACROS_SVH
`ifndef SYNTH
`define EAG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define EAG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EAG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define EAG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/eag_pkg.sv @@
// Shared types, operation codes and constants of the autofocus gradient block
package eag_pkg;

    typedef logic [5:0] t_op;

    localparam t_op OP_IDLE    = 6'd0;
    localparam t_op OP_X_MUL   = 6'd1;
    localparam t_op OP_X_WB    = 6'd2;
    localparam t_op OP_X2_MUL  = 6'd3;
    localparam t_op OP_X2_WB   = 6'd4;
    localparam t_op OP_TS_MUL  = 6'd5;
    localparam t_op OP_TS_DIV  = 6'd6;
    localparam t_op OP_TS_WAIT = 6'd7;
    localparam t_op OP_TS_WB   = 6'd8;
    localparam t_op OP_TC_MUL  = 6'd9;
    localparam t_op OP_TC_DIV  = 6'd10;
    localparam t_op OP_TC_WAIT = 6'd11;
    localparam t_op OP_TC_WB   = 6'd12;
    localparam t_op OP_CLAMP   = 6'd13;
    localparam t_op OP_U1_MUL  = 6'd14;
    localparam t_op OP_U1_WB   = 6'd15;
    localparam t_op OP_U2_MUL  = 6'd16;
    localparam t_op OP_U2_WB   = 6'd17;
    localparam t_op OP_U_RND   = 6'd18;
    localparam t_op OP_V1_MUL  = 6'd19;
    localparam t_op OP_V1_WB   = 6'd20;
    localparam t_op OP_V2_MUL  = 6'd21;
    localparam t_op OP_V2_WB   = 6'd22;
    localparam t_op OP_V_RND   = 6'd23;
    localparam t_op OP_Z1_MUL  = 6'd24;
    localparam t_op OP_Z1_WB   = 6'd25;
    localparam t_op OP_Z2_MUL  = 6'd26;
    localparam t_op OP_Z2_WB   = 6'd27;
    localparam t_op OP_ZCHK    = 6'd28;
    localparam t_op OP_NORM    = 6'd29;
    localparam t_op OP_LX_INIT = 6'd30;
    localparam t_op OP_LX_MUL  = 6'd31;
    localparam t_op OP_LX_WB   = 6'd32;
    localparam t_op OP_L2      = 6'd33;
    localparam t_op OP_LN_MUL  = 6'd34;
    localparam t_op OP_LN_WB   = 6'd35;
    localparam t_op OP_UV_MUL  = 6'd36;
    localparam t_op OP_UV_WB   = 6'd37;
    localparam t_op OP_P0_MUL  = 6'd38;
    localparam t_op OP_P0_WB   = 6'd39;
    localparam t_op OP_P1_MUL  = 6'd40;
    localparam t_op OP_P1_WB   = 6'd41;
    localparam t_op OP_TERM    = 6'd42;
    localparam t_op OP_SUM     = 6'd43;
    localparam t_op OP_FIN     = 6'd44;

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
    localparam logic [62:0] SUM_MAG_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 8;

    localparam logic [2:0] K_LAST   = 3'd7;
    localparam logic [4:0] NORM_END = 5'd5;
    localparam logic [4:0] LN_END   = 5'd23;

    typedef struct packed {
        t_op        op;
        logic [2:0] k;
        logic [4:0] cnt;
        logic       load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic zmag_zero;
        logic out_full;
        logic last;
    } t_stat;

    // divisor of the k-th sine Taylor term: 2k(2k+1)
    function automatic logic [DIV_DEN_W-1:0] sin_den(input logic [2:0] k);
        logic [DIV_DEN_W-1:0] d;
        case (k)
            3'd1:    d = 8'd6;
            3'd2:    d = 8'd20;
            3'd3:    d = 8'd42;
            3'd4:    d = 8'd72;
            3'd5:    d = 8'd110;
            3'd6:    d = 8'd156;
            3'd7:    d = 8'd210;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

    // divisor of the k-th cosine Taylor term: (2k-1)2k
    function automatic logic [DIV_DEN_W-1:0] cos_den(input logic [2:0] k);
        logic [DIV_DEN_W-1:0] d;
        case (k)
            3'd1:    d = 8'd2;
            3'd2:    d = 8'd12;
            3'd3:    d = 8'd30;
            3'd4:    d = 8'd56;
            3'd5:    d = 8'd90;
            3'd6:    d = 8'd132;
            3'd7:    d = 8'd182;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/eag_div.sv @@
// Divider by a small constant: reciprocal multiplication, then add and shift
module eag_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [eag_pkg::DIV_NUM_W-1:0]   i_num,
    input  logic [eag_pkg::DIV_DEN_W-1:0]   i_den,
    output logic                            o_done,
    output logic [eag_pkg::DIV_NUM_W-1:0]   o_quo
);

    localparam int NW = eag_pkg::DIV_NUM_W;

    logic                 r_busy;
    logic                 r_done;
    logic [NW-1:0]        r_num;
    logic [2*NW-1:0]      r_prod;
    logic [5:0]           r_sh;
    logic [NW-1:0]        r_quo;
    logic [NW-1:0]        w_mlo;
    logic [5:0]           w_sh;
    logic [2*NW:0]        w_full;

    // reciprocal ceil(2^(32+l)/d) with l = clog2(d); its bit 32 is always set and implied
    always_comb begin
        unique case (i_den)
            8'd2:   begin w_mlo = NW'(((65'd1 << 33) + 65'd1) / 65'd2);     w_sh = 6'd33; end
            8'd6:   begin w_mlo = NW'(((65'd1 << 35) + 65'd5) / 65'd6);     w_sh = 6'd35; end
            8'd12:  begin w_mlo = NW'(((65'd1 << 36) + 65'd11) / 65'd12);   w_sh = 6'd36; end
            8'd20:  begin w_mlo = NW'(((65'd1 << 37) + 65'd19) / 65'd20);   w_sh = 6'd37; end
            8'd30:  begin w_mlo = NW'(((65'd1 << 37) + 65'd29) / 65'd30);   w_sh = 6'd37; end
            8'd42:  begin w_mlo = NW'(((65'd1 << 38) + 65'd41) / 65'd42);   w_sh = 6'd38; end
            8'd56:  begin w_mlo = NW'(((65'd1 << 38) + 65'd55) / 65'd56);   w_sh = 6'd38; end
            8'd72:  begin w_mlo = NW'(((65'd1 << 39) + 65'd71) / 65'd72);   w_sh = 6'd39; end
            8'd90:  begin w_mlo = NW'(((65'd1 << 39) + 65'd89) / 65'd90);   w_sh = 6'd39; end
            8'd110: begin w_mlo = NW'(((65'd1 << 39) + 65'd109) / 65'd110); w_sh = 6'd39; end
            8'd132: begin w_mlo = NW'(((65'd1 << 40) + 65'd131) / 65'd132); w_sh = 6'd40; end
            8'd156: begin w_mlo = NW'(((65'd1 << 40) + 65'd155) / 65'd156); w_sh = 6'd40; end
            8'd182: begin w_mlo = NW'(((65'd1 << 40) + 65'd181) / 65'd182); w_sh = 6'd40; end
            8'd210: begin w_mlo = NW'(((65'd1 << 40) + 65'd209) / 65'd210); w_sh = 6'd40; end
            default: begin w_mlo = '0; w_sh = 6'd32; end
        endcase
    end

    assign w_full = {1'b0, r_num, {NW{1'b0}}} + {1'b0, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    // multiply on start, then add the implied top bit and shift into the registered quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_prod <= (2*NW)'(i_num) * (2*NW)'(w_mlo);
            r_sh   <= w_sh;
        end
        if (r_busy) begin
            r_quo <= NW'(w_full >> r_sh);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

@@ rtl/eag_dp.sv @@
// Datapath: shared multiplier, divider, log and accumulator registers
module eag_dp #(
    parameter int DATA_WIDTH = 24,
    parameter int PHASE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  eag_pkg::t_cmd                i_cmd,
    input  logic [PHASE_BITS-1:0]        i_phase,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    input  logic signed [DATA_WIDTH-1:0] i_z_re,
    input  logic signed [DATA_WIDTH-1:0] i_z_im,
    input  logic                         i_last,
    input  logic                         i_out_ready,
    output eag_pkg::t_stat               o_stat,
    output logic                         o_out_valid,
    output logic [63:0]                  o_gradient,
    output logic                         o_zero_seen
);

    localparam int FRAC = DATA_WIDTH - 4;
    localparam int RW   = PHASE_BITS - 2;
    localparam int TS   = 2 * FRAC - 10;

    function automatic logic [31:0] mag_d(input logic signed [DATA_WIDTH-1:0] a);
        logic signed [DATA_WIDTH:0] e;
        e = {a[DATA_WIDTH-1], a};
        if (e < 0) e = -e;
        return 32'(e[DATA_WIDTH-1:0]);
    endfunction

    logic [PHASE_BITS-1:0]        r_ph;
    logic signed [DATA_WIDTH-1:0] r_br, r_bi, r_zr, r_zi;
    logic                         r_last;
    logic [63:0]                  r_mul;
    logic [31:0]                  r_x, r_x2, r_ts, r_tc;
    logic signed [33:0]           r_ss, r_cc;
    logic signed [31:0]           r_c, r_s;
    logic signed [63:0]           r_acc;
    logic signed [33:0]           r_u, r_v;
    logic [63:0]                  r_zmag;
    logic [5:0]                   r_lz;
    logic [31:0]                  r_lx;
    logic [23:0]                  r_frac;
    logic signed [31:0]           r_l2;
    logic signed [32:0]           r_l;
    logic [63:0]                  r_uv;
    logic [96:0]                  r_wide;
    logic signed [63:0]           r_term;
    logic signed [63:0]           r_sum;
    logic                         r_zf;
    logic                         r_ovalid;
    logic [63:0]                  r_ograd;
    logic                         r_ozf;

    logic [31:0]                  w_mul_a, w_mul_b;
    logic                         w_div_start;
    logic [eag_pkg::DIV_DEN_W-1:0] w_div_den;
    logic                         w_div_done;
    logic [eag_pkg::DIV_NUM_W-1:0] w_div_q;
    logic [31:0]                  w_q32;
    logic [31:0]                  w_c_mag, w_s_mag, w_u_mag, w_v_mag, w_l_mag, w_l2_mag;
    logic signed [63:0]           w_prod;
    logic                         w_pneg;
    logic [63:0]                  w_am, w_rm;
    logic signed [33:0]           w_rnd;
    logic signed [31:0]           w_ssc, w_ccc;
    logic [5:0]                   w_nsh;
    logic                         w_top_zero;
    logic [63:0]                  w_lxt;
    logic signed [31:0]           w_e2;
    logic [63:0]                  w_lnm;
    logic signed [32:0]           w_ln;
    logic [96:0]                  w_rnd97, w_sh97;
    logic [62:0]                  w_tmag;
    logic                         w_tneg;
    logic signed [64:0]           w_s65;
    logic signed [63:0]           w_sat;
    logic                         w_out_full;
    logic                         w_emit;

    assign w_c_mag  = r_c[31] ? 32'(-r_c) : 32'(r_c);
    assign w_s_mag  = r_s[31] ? 32'(-r_s) : 32'(r_s);
    assign w_u_mag  = r_u[33] ? 32'(-r_u) : 32'(r_u);
    assign w_v_mag  = r_v[33] ? 32'(-r_v) : 32'(r_v);
    assign w_l_mag  = r_l[32] ? 32'(-r_l) : 32'(r_l);
    assign w_l2_mag = r_l2[31] ? 32'(-r_l2) : 32'(r_l2);

    // operand select of the shared multiplier
    always_comb begin
        unique case (i_cmd.op)
            eag_pkg::OP_X_MUL: begin
                w_mul_a = 32'(r_ph[RW-1:0]);
                w_mul_b = eag_pkg::HALF_PI_Q30;
            end
            eag_pkg::OP_X2_MUL:  begin w_mul_a = r_x;            w_mul_b = r_x;       end
            eag_pkg::OP_TS_MUL:  begin w_mul_a = r_ts;           w_mul_b = r_x2;      end
            eag_pkg::OP_TC_MUL:  begin w_mul_a = r_tc;           w_mul_b = r_x2;      end
            eag_pkg::OP_U1_MUL:  begin w_mul_a = mag_d(r_br);    w_mul_b = w_c_mag;   end
            eag_pkg::OP_U2_MUL:  begin w_mul_a = mag_d(r_bi);    w_mul_b = w_s_mag;   end
            eag_pkg::OP_V1_MUL:  begin w_mul_a = mag_d(r_bi);    w_mul_b = w_c_mag;   end
            eag_pkg::OP_V2_MUL:  begin w_mul_a = mag_d(r_br);    w_mul_b = w_s_mag;   end
            eag_pkg::OP_Z1_MUL:  begin w_mul_a = mag_d(r_zr);    w_mul_b = mag_d(r_zr); end
            eag_pkg::OP_Z2_MUL:  begin w_mul_a = mag_d(r_zi);    w_mul_b = mag_d(r_zi); end
            eag_pkg::OP_LX_MUL:  begin w_mul_a = r_lx;           w_mul_b = r_lx;      end
            eag_pkg::OP_LN_MUL:  begin w_mul_a = w_l2_mag;       w_mul_b = eag_pkg::LN2_Q32; end
            eag_pkg::OP_UV_MUL:  begin w_mul_a = w_u_mag;        w_mul_b = w_v_mag;   end
            eag_pkg::OP_P0_MUL:  begin w_mul_a = r_uv[31:0];     w_mul_b = w_l_mag;   end
            eag_pkg::OP_P1_MUL:  begin w_mul_a = r_uv[63:32];    w_mul_b = w_l_mag;   end
            default:             begin w_mul_a = '0;             w_mul_b = '0;        end
        endcase
    end

    // sign of the product now in r_mul
    always_comb begin
        unique case (i_cmd.op)
            eag_pkg::OP_U1_WB: w_pneg = r_br[DATA_WIDTH-1] ^ r_c[31];
            eag_pkg::OP_U2_WB: w_pneg = r_bi[DATA_WIDTH-1] ^ r_s[31];
            eag_pkg::OP_V1_WB: w_pneg = r_bi[DATA_WIDTH-1] ^ r_c[31];
            eag_pkg::OP_V2_WB: w_pneg = r_br[DATA_WIDTH-1] ^ r_s[31];
            default:           w_pneg = 1'b0;
        endcase
    end
    assign w_prod = w_pneg ? -$signed(r_mul) : $signed(r_mul);

    assign w_div_start = (i_cmd.op == eag_pkg::OP_TS_DIV) || (i_cmd.op == eag_pkg::OP_TC_DIV);
    assign w_div_den   = (i_cmd.op == eag_pkg::OP_TS_DIV) ? eag_pkg::sin_den(i_cmd.k)
                                                          : eag_pkg::cos_den(i_cmd.k);

    eag_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (eag_pkg::DIV_NUM_W'(r_mul >> 30)),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_q)
    );
    assign w_q32 = w_div_q[31:0];

    // round half away from zero, 30 bits
    assign w_am  = r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
    assign w_rm  = (w_am + (64'd1 << 29)) >> 30;
    assign w_rnd = r_acc[63] ? -$signed(34'(w_rm)) : $signed(34'(w_rm));

    assign w_ssc = (r_ss < 0) ? 32'sd0 :
                   (r_ss > $signed({2'b00, eag_pkg::ONE_Q30})) ? $signed(eag_pkg::ONE_Q30) :
                   32'(r_ss);
    assign w_ccc = (r_cc < 0) ? 32'sd0 :
                   (r_cc > $signed({2'b00, eag_pkg::ONE_Q30})) ? $signed(eag_pkg::ONE_Q30) :
                   32'(r_cc);

    assign w_nsh      = 6'd32 >> i_cmd.cnt[2:0];
    assign w_top_zero = ((r_zmag & ~(64'hFFFF_FFFF_FFFF_FFFF >> w_nsh)) == 64'd0);

    assign w_lxt = r_mul >> 30;
    assign w_e2  = $signed(32'(63 - 2 * FRAC)) - $signed({26'd0, r_lz});
    assign w_lnm = (r_mul + 64'h8000_0000) >> 32;
    assign w_ln  = r_l2[31] ? -$signed({1'b0, w_lnm[31:0]}) : $signed({1'b0, w_lnm[31:0]});

    assign w_rnd97 = r_wide + (97'd1 << (TS - 1));
    assign w_sh97  = w_rnd97 >> TS;
    assign w_tmag  = (|w_sh97[96:63]) ? eag_pkg::SUM_MAG_MAX : w_sh97[62:0];
    assign w_tneg  = r_u[33] ^ r_v[33] ^ r_l[32];

    assign w_s65 = {r_sum[63], r_sum} + {r_term[63], r_term};
    assign w_sat = (w_s65[64] != w_s65[63]) ?
                   (w_s65[64] ? $signed({1'b1, 63'd0}) : $signed({1'b0, eag_pkg::SUM_MAG_MAX}))
                   : w_s65[63:0];

    assign w_out_full = r_ovalid && !i_out_ready;
    assign w_emit     = (i_cmd.op == eag_pkg::OP_FIN) && r_last && !w_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_zf     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_emit) begin
                r_sum <= '0;
                r_zf  <= 1'b0;
            end else if (i_cmd.op == eag_pkg::OP_SUM) begin
                r_sum <= w_sat;
            end else if ((i_cmd.op == eag_pkg::OP_ZCHK) && (r_zmag == 64'd0)) begin
                r_zf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= 64'(w_mul_a) * 64'(w_mul_b);
        if (i_cmd.load) begin
            r_ph   <= i_phase;
            r_br   <= i_b_re;
            r_bi   <= i_b_im;
            r_zr   <= i_z_re;
            r_zi   <= i_z_im;
            r_last <= i_last;
        end
        if (w_emit) begin
            r_ograd <= r_sum;
            r_ozf   <= r_zf;
        end
        unique case (i_cmd.op)
            eag_pkg::OP_X_WB: r_x <= 32'(r_mul >> RW);
            eag_pkg::OP_X2_WB: begin
                r_x2 <= 32'(r_mul >> 30);
                r_ts <= r_x;
                r_tc <= eag_pkg::ONE_Q30;
                r_ss <= $signed({2'b00, r_x});
                r_cc <= $signed({2'b00, eag_pkg::ONE_Q30});
            end
            eag_pkg::OP_TS_WB: begin
                r_ts <= w_q32;
                r_ss <= i_cmd.k[0] ? r_ss - $signed({2'b00, w_q32})
                                   : r_ss + $signed({2'b00, w_q32});
            end
            eag_pkg::OP_TC_WB: begin
                r_tc <= w_q32;
                r_cc <= i_cmd.k[0] ? r_cc - $signed({2'b00, w_q32})
                                   : r_cc + $signed({2'b00, w_q32});
            end
            eag_pkg::OP_CLAMP: begin
                case (r_ph[PHASE_BITS-1 -: 2])
                    2'd0:    begin r_c <= w_ccc;  r_s <= w_ssc;  end
                    2'd1:    begin r_c <= -w_ssc; r_s <= w_ccc;  end
                    2'd2:    begin r_c <= -w_ccc; r_s <= -w_ssc; end
                    default: begin r_c <= w_ssc;  r_s <= -w_ccc; end
                endcase
            end
            eag_pkg::OP_U1_WB, eag_pkg::OP_V1_WB: r_acc <= w_prod;
            eag_pkg::OP_U2_WB: r_acc <= r_acc + w_prod;
            eag_pkg::OP_V2_WB: r_acc <= r_acc - w_prod;
            eag_pkg::OP_U_RND: r_u <= w_rnd;
            eag_pkg::OP_V_RND: r_v <= w_rnd;
            eag_pkg::OP_Z1_WB: r_zmag <= r_mul;
            eag_pkg::OP_Z2_WB: r_zmag <= r_zmag + r_mul;
            eag_pkg::OP_ZCHK:  r_lz <= '0;
            eag_pkg::OP_NORM: begin
                if (w_top_zero) begin
                    r_zmag <= r_zmag << w_nsh;
                    r_lz   <= r_lz + w_nsh;
                end
            end
            eag_pkg::OP_LX_INIT: begin
                r_lx   <= {1'b0, r_zmag[63:33]};
                r_frac <= '0;
            end
            eag_pkg::OP_LX_WB: begin
                if (w_lxt[31]) begin
                    r_lx   <= w_lxt[32:1];
                    r_frac <= {r_frac[22:0], 1'b1};
                end else begin
                    r_lx   <= w_lxt[31:0];
                    r_frac <= {r_frac[22:0], 1'b0};
                end
            end
            eag_pkg::OP_L2:    r_l2 <= (w_e2 <<< 24) + $signed({8'd0, r_frac});
            eag_pkg::OP_LN_WB: r_l <= w_ln + 33'sd16777216;
            eag_pkg::OP_UV_WB: r_uv <= r_mul;
            eag_pkg::OP_P0_WB: r_wide <= 97'(r_mul);
            eag_pkg::OP_P1_WB: r_wide <= r_wide + (97'(r_mul) << 32);
            eag_pkg::OP_TERM:
                r_term <= w_tneg ? -$signed({1'b0, w_tmag}) : $signed({1'b0, w_tmag});
            default: ;
        endcase
    end

    assign o_stat.div_done  = w_div_done;
    assign o_stat.zmag_zero = (r_zmag == 64'd0);
    assign o_stat.out_full  = w_out_full;
    assign o_stat.last      = r_last;
    assign o_out_valid      = r_ovalid;
    assign o_gradient       = r_ograd;
    assign o_zero_seen      = r_ozf;

endmodule

@@ rtl/eag_ctrl.sv @@
// Controller: sequences datapath operations for one beat
module eag_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  eag_pkg::t_stat i_stat,
    output logic           o_ready,
    output eag_pkg::t_cmd  o_cmd
);

    eag_pkg::t_op r_state, n_state;
    logic [2:0]   r_k, n_k;
    logic [4:0]   r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_cnt   = r_cnt;
        unique case (r_state)
            eag_pkg::OP_IDLE:    if (i_valid) n_state = eag_pkg::OP_X_MUL;
            eag_pkg::OP_X_MUL:   n_state = eag_pkg::OP_X_WB;
            eag_pkg::OP_X_WB:    n_state = eag_pkg::OP_X2_MUL;
            eag_pkg::OP_X2_MUL:  n_state = eag_pkg::OP_X2_WB;
            eag_pkg::OP_X2_WB: begin
                n_state = eag_pkg::OP_TS_MUL;
                n_k     = 3'd1;
            end
            eag_pkg::OP_TS_MUL:  n_state = eag_pkg::OP_TS_DIV;
            eag_pkg::OP_TS_DIV:  n_state = eag_pkg::OP_TS_WAIT;
            eag_pkg::OP_TS_WAIT: if (i_stat.div_done) n_state = eag_pkg::OP_TS_WB;
            eag_pkg::OP_TS_WB:   n_state = eag_pkg::OP_TC_MUL;
            eag_pkg::OP_TC_MUL:  n_state = eag_pkg::OP_TC_DIV;
            eag_pkg::OP_TC_DIV:  n_state = eag_pkg::OP_TC_WAIT;
            eag_pkg::OP_TC_WAIT: if (i_stat.div_done) n_state = eag_pkg::OP_TC_WB;
            eag_pkg::OP_TC_WB: begin
                if (r_k == eag_pkg::K_LAST) begin
                    n_state = eag_pkg::OP_CLAMP;
                end else begin
                    n_state = eag_pkg::OP_TS_MUL;
                    n_k     = r_k + 3'd1;
                end
            end
            eag_pkg::OP_CLAMP:   n_state = eag_pkg::OP_U1_MUL;
            eag_pkg::OP_U1_MUL:  n_state = eag_pkg::OP_U1_WB;
            eag_pkg::OP_U1_WB:   n_state = eag_pkg::OP_U2_MUL;
            eag_pkg::OP_U2_MUL:  n_state = eag_pkg::OP_U2_WB;
            eag_pkg::OP_U2_WB:   n_state = eag_pkg::OP_U_RND;
            eag_pkg::OP_U_RND:   n_state = eag_pkg::OP_V1_MUL;
            eag_pkg::OP_V1_MUL:  n_state = eag_pkg::OP_V1_WB;
            eag_pkg::OP_V1_WB:   n_state = eag_pkg::OP_V2_MUL;
            eag_pkg::OP_V2_MUL:  n_state = eag_pkg::OP_V2_WB;
            eag_pkg::OP_V2_WB:   n_state = eag_pkg::OP_V_RND;
            eag_pkg::OP_V_RND:   n_state = eag_pkg::OP_Z1_MUL;
            eag_pkg::OP_Z1_MUL:  n_state = eag_pkg::OP_Z1_WB;
            eag_pkg::OP_Z1_WB:   n_state = eag_pkg::OP_Z2_MUL;
            eag_pkg::OP_Z2_MUL:  n_state = eag_pkg::OP_Z2_WB;
            eag_pkg::OP_Z2_WB:   n_state = eag_pkg::OP_ZCHK;
            eag_pkg::OP_ZCHK: begin
                // zero magnitude adds nothing: skip straight to the column check
                n_state = i_stat.zmag_zero ? eag_pkg::OP_FIN : eag_pkg::OP_NORM;
                n_cnt   = '0;
            end
            eag_pkg::OP_NORM: begin
                if (r_cnt == eag_pkg::NORM_END) begin
                    n_state = eag_pkg::OP_LX_INIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            eag_pkg::OP_LX_INIT: n_state = eag_pkg::OP_LX_MUL;
            eag_pkg::OP_LX_MUL:  n_state = eag_pkg::OP_LX_WB;
            eag_pkg::OP_LX_WB: begin
                if (r_cnt == eag_pkg::LN_END) begin
                    n_state = eag_pkg::OP_L2;
                end else begin
                    n_state = eag_pkg::OP_LX_MUL;
                    n_cnt   = r_cnt + 5'd1;
                end
            end
            eag_pkg::OP_L2:      n_state = eag_pkg::OP_LN_MUL;
            eag_pkg::OP_LN_MUL:  n_state = eag_pkg::OP_LN_WB;
            eag_pkg::OP_LN_WB:   n_state = eag_pkg::OP_UV_MUL;
            eag_pkg::OP_UV_MUL:  n_state = eag_pkg::OP_UV_WB;
            eag_pkg::OP_UV_WB:   n_state = eag_pkg::OP_P0_MUL;
            eag_pkg::OP_P0_MUL:  n_state = eag_pkg::OP_P0_WB;
            eag_pkg::OP_P0_WB:   n_state = eag_pkg::OP_P1_MUL;
            eag_pkg::OP_P1_MUL:  n_state = eag_pkg::OP_P1_WB;
            eag_pkg::OP_P1_WB:   n_state = eag_pkg::OP_TERM;
            eag_pkg::OP_TERM:    n_state = eag_pkg::OP_SUM;
            eag_pkg::OP_SUM:     n_state = eag_pkg::OP_FIN;
            eag_pkg::OP_FIN: begin
                // at a column end, hold while a previous result still waits in the output register
                if (!(i_stat.last && i_stat.out_full)) n_state = eag_pkg::OP_IDLE;
            end
            default:             n_state = eag_pkg::OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eag_pkg::OP_IDLE;
            r_k     <= 3'd1;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
        end
    end

    assign o_ready    = (r_state == eag_pkg::OP_IDLE);
    assign o_cmd.op   = r_state;
    assign o_cmd.k    = r_k;
    assign o_cmd.cnt  = r_cnt;
    assign o_cmd.load = (r_state == eag_pkg::OP_IDLE) && i_valid;

endmodule

@@ rtl/entropy_autofocus_gradient.sv @@
// Top level of the minimum-entropy autofocus gradient block
//
//  channel   dir  tdata (low bit up)                      tlast           tuser
//  s_axis    in   phase, b_re, b_im, z_re, z_im           last_in_column  -
//  m_axis    out  gradient                                -               zero_magnitude_seen
//
// One beat at a time: a beat is taken only while the controller is idle; a zero
// image magnitude skips the log and the term. Each of the fourteen Taylor terms
// takes a multiply, a reciprocal divide and a write back; the log adds 24 squaring
// steps on the shared 32x32 multiplier. A result is raised at the end of a column
// and waits in an output register; the next beat is taken meanwhile, and only a
// second result waits for the first to leave.
// Reset is synchronous, active low; it clears the sum, zero flag and output valid.

`include "entropy_autofocus_gradient_macros.svh"

module entropy_autofocus_gradient #(
    parameter int DATA_WIDTH = 24,
    parameter int PHASE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // phase, b_re, b_im, z_re, z_im
    input  logic [((PHASE_BITS + 4 * DATA_WIDTH + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // gradient
    output logic [63:0]           o_m_axis_tdata,
    // zero_magnitude_seen
    output logic                  o_m_axis_tuser
);

    eag_pkg::t_cmd  w_cmd;
    eag_pkg::t_stat w_stat;

    eag_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_stat  (w_stat),
        .o_ready (o_s_axis_tready),
        .o_cmd   (w_cmd)
    );

    eag_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_phase     (i_s_axis_tdata[PHASE_BITS-1:0]),
        .i_b_re      ($signed(i_s_axis_tdata[PHASE_BITS +: DATA_WIDTH])),
        .i_b_im      ($signed(i_s_axis_tdata[PHASE_BITS + DATA_WIDTH +: DATA_WIDTH])),
        .i_z_re      ($signed(i_s_axis_tdata[PHASE_BITS + 2 * DATA_WIDTH +: DATA_WIDTH])),
        .i_z_im      ($signed(i_s_axis_tdata[PHASE_BITS + 3 * DATA_WIDTH +: DATA_WIDTH])),
        .i_last      (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_stat      (w_stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_gradient  (o_m_axis_tdata),
        .o_zero_seen (o_m_axis_tuser)
    );

    `EAG_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input taken while a beat is in progress")
    `EAG_ASSERT_NXT(a_load_starts_seq, i_clk, i_rst_n, w_cmd.load, w_cmd.op == eag_pkg::OP_X_MUL, "sequence did not start after load")
    `EAG_ASSERT_IMP(a_emit_from_fin, i_clk, i_rst_n, $rose(o_m_axis_tvalid), ($past(w_cmd.op) == eag_pkg::OP_FIN) && $past(w_stat.last), "result raised outside column end")

endmodule
